### rtl/core/probability_vector_rank_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the probability vector rank engine
// Clocked, reset-gated implication checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PROBABILITY_VECTOR_RANK_ENGINE_ASSERT_SVH
`define PROBABILITY_VECTOR_RANK_ENGINE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define PVRE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pvre same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define PVRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pvre next-cycle check failed");

`endif

### rtl/core/pvre_pkg.sv
// ----------------------------------------------------------------------------
// pvre_pkg
// Types and constants shared by the probability vector rank engine.
// ----------------------------------------------------------------------------
package pvre_pkg;

   localparam int VALUE_W = 16;   // Q1.15 probability
   localparam int INDEX_W = 5;    // reported index and position field
   localparam int LEN_W   = 6;    // active length register and scan index

   localparam logic [VALUE_W-1:0] ONE_Q15   = 16'd32768;
   localparam logic [LEN_W-1:0]   LEN_RESET = 6'd32;

   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_AVG   = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [INDEX_W-1:0] position;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] max_index;
      logic [VALUE_W-1:0] max_value;
      logic [INDEX_W-1:0] min_index;
      logic [VALUE_W-1:0] min_value;
      logic [INDEX_W-1:0] rank_index;
      logic [VALUE_W-1:0] rank_value;
      logic               rank_valid;
   } rsp_type;

   typedef struct packed {
      logic gt_a;   // q > a
      logic lt_b;   // q < b
      logic eq_b;   // q == b
   } cmp_flags_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_WR,
      ST_MM,
      ST_RK_P,
      ST_RK_PW,
      ST_RK_Q,
      ST_DONE
   } seq_state_type;

endpackage

### rtl/core/probability_vector_rank_engine.sv
// ----------------------------------------------------------------------------
// probability_vector_rank_engine
// Probability vector with update, min/max scan and order-statistic query.
// ----------------------------------------------------------------------------
// Use:
//   Command channel: present req_data and raise start; the transfer happens
//   on the edge where start is high and busy is low. busy then stays high
//   until the result has been shown.
//   Result channel: rsp_data is valid for exactly one cycle, marked by
//   rsp_strobe. The receiver cannot stall; it must take the transfer then.
//   Config channel: csr_valid/csr_ready write active_length; csr_ready is
//   always high. Write it only while the block is idle.
// Sequence (L = active length after clamping to 1..DEPTH):
//   write item:   update write, average item: update read then write;
//   min/max pass: all L elements through the single RAM read port;
//   query item:   adds a rank pass, one outer element at a time, each
//                 streaming all L elements through the compare unit;
//                 the pass stops at the first element of that rank;
//   then the strobe state.
// Reset: the vector RAM is cleared by a pass over all DEPTH entries,
//   one a cycle, busy high; config writes are taken during that pass.
// ----------------------------------------------------------------------------
`include "probability_vector_rank_engine_assert.svh"

module probability_vector_rank_engine
   import pvre_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [LEN_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(DEPTH);

   // Sequencer and control registers
   seq_state_type      state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic [LEN_W-1:0]   csr_len_ff, csr_len_in;
   logic               dv_ff, dv_in;

   // Item and scan registers
   logic [1:0]         kind_ff, kind_in;
   logic [INDEX_W-1:0] pos_ff, pos_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [LEN_W-1:0]   iss_ff, iss_in;
   logic [LEN_W-1:0]   tag_ff, tag_in;
   logic [VALUE_W-1:0] max_v_ff, max_v_in;
   logic [VALUE_W-1:0] min_v_ff, min_v_in;
   logic [LEN_W-1:0]   max_i_ff, max_i_in;
   logic [LEN_W-1:0]   min_i_ff, min_i_in;
   logic [LEN_W-1:0]   less_ff, less_in;
   logic [LEN_W-1:0]   leq_ff, leq_in;
   logic [LEN_W-1:0]   outer_ff, outer_in;
   logic [VALUE_W-1:0] p_ff, p_in;
   logic [LEN_W-1:0]   rk_i_ff, rk_i_in;
   logic [VALUE_W-1:0] rk_v_ff, rk_v_in;
   logic               rk_ok_ff, rk_ok_in;

   // RAM port and compare unit signals
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [VALUE_W-1:0] ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [VALUE_W-1:0] ram_rdata;
   logic [VALUE_W-1:0] cmp_a;
   logic [VALUE_W-1:0] cmp_b;
   cmp_flags_type      flags;

   // Derived control
   logic [LEN_W-1:0]   len;
   logic               accept;
   logic               req_pos_ok;
   logic               pos_ok;
   logic               issue;
   logic               last_data;
   logic [LEN_W-1:0]   less_fin;
   logic [LEN_W-1:0]   leq_fin;
   logic               found;
   logic [VALUE_W-1:0] req_val_sat;
   logic [VALUE_W-1:0] avg_val;

   // Result properties watched by the checks at the end
   logic               rsp_order_ok;
   logic               rsp_rank_zero;

   // Clamp the length register to 1..DEPTH.
   always_comb begin
      if (csr_len_ff == '0) begin
         len = LEN_W'(1);
      end else if (int'(csr_len_ff) > DEPTH) begin
         len = LEN_W'(DEPTH);
      end else begin
         len = csr_len_ff;
      end
   end

   assign accept      = start && (state_ff == ST_IDLE);
   assign req_pos_ok  = ({1'b0, req_data.position} < len);
   assign pos_ok      = ({1'b0, pos_ff} < len);
   assign issue       = (iss_ff < len);
   assign last_data   = dv_ff && (tag_ff == (len - LEN_W'(1)));
   assign less_fin    = less_ff + LEN_W'(flags.lt_b);
   assign leq_fin     = leq_ff + LEN_W'(flags.lt_b | flags.eq_b);
   assign found       = (less_fin <= {1'b0, pos_ff}) && ({1'b0, pos_ff} < leq_fin);
   assign req_val_sat = (req_data.value > ONE_Q15) ? ONE_Q15 : req_data.value;
   assign avg_val     = VALUE_W'(({1'b0, ram_rdata} + {1'b0, val_ff}) >> 1);

   // The compare unit sees the running max/min during the min/max pass and
   // the outer element during the rank pass.
   assign cmp_a = (state_ff == ST_RK_Q) ? p_ff : max_v_ff;
   assign cmp_b = (state_ff == ST_RK_Q) ? p_ff : min_v_ff;

   pvre_cmp u_cmp (
      .q     (ram_rdata),
      .a     (cmp_a),
      .b     (cmp_b),
      .flags (flags)
   );

   pvre_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_pos_ok && (req_data.kind == KIND_WRITE)) begin
                  state_in = ST_UPD_WR;
               end else if (req_pos_ok && (req_data.kind == KIND_AVG)) begin
                  state_in = ST_UPD_RD;
               end else begin
                  state_in = ST_MM;
               end
            end
         end
         ST_UPD_RD: state_in = ST_UPD_WR;
         ST_UPD_WR: state_in = ST_MM;
         ST_MM: begin
            if (last_data) begin
               if ((kind_ff == KIND_QUERY) && pos_ok) begin
                  state_in = ST_RK_P;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RK_P:  state_in = ST_RK_PW;
         ST_RK_PW: state_in = ST_RK_Q;
         ST_RK_Q: begin
            if (last_data) begin
               if (found || (outer_ff == (len - LEN_W'(1)))) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RK_P;
               end
            end
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: RAM ports and handshake
   always_comb begin
      busy      = 1'b1;
      rsp_strobe = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = ADDR_W'(pos_ff);
      ram_wdata = val_ff;
      ram_raddr = ADDR_W'(iss_ff);
      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_ff;
            ram_wdata = '0;
         end
         ST_IDLE: busy = 1'b0;
         ST_UPD_RD: ram_raddr = ADDR_W'(pos_ff);
         ST_UPD_WR: begin
            ram_we    = 1'b1;
            ram_wdata = (kind_ff == KIND_AVG) ? avg_val : val_ff;
         end
         ST_RK_P: ram_raddr = ADDR_W'(outer_ff);
         ST_DONE: rsp_strobe = 1'b1;
         default: begin
         end
      endcase
   end

   assign csr_ready = 1'b1;

   // Datapath next values
   always_comb begin
      clr_addr_in = clr_addr_ff;
      csr_len_in  = csr_len_ff;
      dv_in       = dv_ff;
      kind_in     = kind_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      iss_in      = iss_ff;
      tag_in      = tag_ff;
      max_v_in    = max_v_ff;
      min_v_in    = min_v_ff;
      max_i_in    = max_i_ff;
      min_i_in    = min_i_ff;
      less_in     = less_ff;
      leq_in      = leq_ff;
      outer_in    = outer_ff;
      p_in        = p_ff;
      rk_i_in     = rk_i_ff;
      rk_v_in     = rk_v_ff;
      rk_ok_in    = rk_ok_ff;

      if (csr_valid) begin
         csr_len_in = csr_data;
      end

      case (state_ff)
         ST_CLEAR: clr_addr_in = clr_addr_ff + ADDR_W'(1);
         ST_IDLE: begin
            if (accept) begin
               kind_in  = req_data.kind;
               pos_in   = req_data.position;
               val_in   = req_val_sat;
               iss_in   = '0;
               dv_in    = 1'b0;
               rk_i_in  = '0;
               rk_v_in  = '0;
               rk_ok_in = 1'b0;
            end
         end
         ST_MM: begin
            // Stream elements: issue one address, consume the one read before.
            dv_in  = issue;
            tag_in = iss_ff;
            if (issue) begin
               iss_in = iss_ff + LEN_W'(1);
            end
            if (dv_ff) begin
               if (tag_ff == '0) begin
                  max_v_in = ram_rdata;
                  min_v_in = ram_rdata;
                  max_i_in = '0;
                  min_i_in = '0;
               end else begin
                  if (flags.gt_a) begin
                     max_v_in = ram_rdata;
                     max_i_in = tag_ff;
                  end
                  if (flags.lt_b) begin
                     min_v_in = ram_rdata;
                     min_i_in = tag_ff;
                  end
               end
            end
            if (last_data) begin
               iss_in   = '0;
               dv_in    = 1'b0;
               outer_in = '0;
               less_in  = '0;
               leq_in   = '0;
            end
         end
         ST_RK_PW: p_in = ram_rdata;
         ST_RK_Q: begin
            dv_in  = issue;
            tag_in = iss_ff;
            if (issue) begin
               iss_in = iss_ff + LEN_W'(1);
            end
            if (dv_ff) begin
               less_in = less_fin;
               leq_in  = leq_fin;
            end
            if (last_data) begin
               if (found) begin
                  rk_i_in  = outer_ff;
                  rk_v_in  = p_ff;
                  rk_ok_in = 1'b1;
               end
               // Advance to the next outer element and restart the counts.
               outer_in = outer_ff + LEN_W'(1);
               iss_in   = '0;
               dv_in    = 1'b0;
               less_in  = '0;
               leq_in   = '0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         csr_len_ff  <= LEN_RESET;
         dv_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         csr_len_ff  <= csr_len_in;
         dv_ff       <= dv_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      iss_ff   <= iss_in;
      tag_ff   <= tag_in;
      max_v_ff <= max_v_in;
      min_v_ff <= min_v_in;
      max_i_ff <= max_i_in;
      min_i_ff <= min_i_in;
      less_ff  <= less_in;
      leq_ff   <= leq_in;
      outer_ff <= outer_in;
      p_ff     <= p_in;
      rk_i_ff  <= rk_i_in;
      rk_v_ff  <= rk_v_in;
      rk_ok_ff <= rk_ok_in;
   end

   // Result payload; indices carry their low bits.
   always_comb begin
      rsp_data.max_index  = max_i_ff[INDEX_W-1:0];
      rsp_data.max_value  = max_v_ff;
      rsp_data.min_index  = min_i_ff[INDEX_W-1:0];
      rsp_data.min_value  = min_v_ff;
      rsp_data.rank_index = rk_i_ff[INDEX_W-1:0];
      rsp_data.rank_value = rk_v_ff;
      rsp_data.rank_valid = rk_ok_ff;
   end

   assign rsp_order_ok  = (rsp_data.min_value <= rsp_data.max_value)
                          && (rsp_data.max_value <= ONE_Q15);
   assign rsp_rank_zero = (rsp_data.rank_value == '0) && (rsp_data.rank_index == '0);

   // Assertions
   `PVRE_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `PVRE_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !busy && !rsp_strobe)
   `PVRE_ASSERT_SAME(a_minmax_order, clock, reset, rsp_strobe, rsp_order_ok)
   `PVRE_ASSERT_SAME(a_rank_cleared, clock, reset, rsp_strobe && !rsp_data.rank_valid, rsp_rank_zero)

endmodule

### rtl/core/pvre_ram.sv
// ----------------------------------------------------------------------------
// pvre_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pvre_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/pvre_cmp.sv
// ----------------------------------------------------------------------------
// pvre_cmp
// Shared compare unit: tests one read element against two references.
// ----------------------------------------------------------------------------
module pvre_cmp
   import pvre_pkg::*;
(
   input  logic [VALUE_W-1:0] q,
   input  logic [VALUE_W-1:0] a,
   input  logic [VALUE_W-1:0] b,
   output cmp_flags_type      flags
);

   always_comb begin
      flags.gt_a = (q > a);
      flags.lt_b = (q < b);
      flags.eq_b = (q == b);
   end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: probability vector rank engine testbench
// Drives write, average, query and unused commands through the start/busy
// channel, changes the active length between phases, and checks each strobed
// report field by field against an in-bench model of the probability vector.
// ----------------------------------------------------------------------------
module tb_top;
   import pvre_pkg::*;

   localparam int          DEPTH       = 32;
   localparam logic [1:0]  KIND_UNUSED = 2'd3;
   localparam int          CYCLE_LIMIT = 4000000;
   localparam int          DRAIN_WAIT  = 1300;   // worst query latency plus margin
   localparam int          PHASES      = 12;
   localparam int          PHASE_ITEMS = 45;

   // -------------------------------------------------------------------------
   // Vector model and report store
   // -------------------------------------------------------------------------
   class rank_tracker;
      logic [VALUE_W-1:0] prob_mem [DEPTH];
      logic [LEN_W-1:0]   length_reg;
      rsp_type            pending_reports [$];
      int                 mismatches;

      function new();
         foreach (prob_mem[i]) prob_mem[i] = '0;
         length_reg  = LEN_RESET;
         mismatches  = 0;
      endfunction

      // Clamp the register to 1..DEPTH.
      function int unsigned live_length();
         if (length_reg == 0) return 1;
         if (length_reg > DEPTH) return DEPTH;
         return 32'(length_reg);
      endfunction

      function rsp_type compute_report(req_type cmd);
         rsp_type            r;
         logic [VALUE_W-1:0] v;
         logic [VALUE_W:0]   sum;
         logic [VALUE_W-1:0] p;
         int unsigned        len, less, leq;
         r   = '0;
         len = live_length();
         v   = (cmd.value > ONE_Q15) ? ONE_Q15 : cmd.value;
         if (cmd.position < len) begin
            if (cmd.kind == KIND_WRITE) begin
               prob_mem[cmd.position] = v;
            end else if (cmd.kind == KIND_AVG) begin
               sum = {1'b0, prob_mem[cmd.position]} + {1'b0, v};
               prob_mem[cmd.position] = sum[VALUE_W:1];
            end
         end
         r.max_value = prob_mem[0];
         r.min_value = prob_mem[0];
         for (int i = 1; i < len; i++) begin
            if (prob_mem[i] > r.max_value) begin
               r.max_value = prob_mem[i];
               r.max_index = i[INDEX_W-1:0];
            end
            if (prob_mem[i] < r.min_value) begin
               r.min_value = prob_mem[i];
               r.min_index = i[INDEX_W-1:0];
            end
         end
         if (cmd.kind == KIND_QUERY && cmd.position < len) begin
            for (int i = 0; i < len; i++) begin
               p    = prob_mem[i];
               less = 0;
               leq  = 0;
               for (int j = 0; j < len; j++) begin
                  if (prob_mem[j] < p) less++;
                  if (prob_mem[j] <= p) leq++;
               end
               if (less <= cmd.position && cmd.position < leq) begin
                  r.rank_index = i[INDEX_W-1:0];
                  r.rank_value = p;
                  r.rank_valid = 1'b1;
                  break;
               end
            end
         end
         return r;
      endfunction

      function void note_command(req_type cmd);
         pending_reports.push_back(compute_report(cmd));
      endfunction

      function void check_field(string name, logic [VALUE_W-1:0] exp_v,
                                logic [VALUE_W-1:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
         end
      endfunction

      function void check_report(rsp_type got);
         rsp_type want;
         if (pending_reports.size() == 0) begin
            $error("report strobed with no command outstanding");
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         check_field("max_index",  want.max_index,  got.max_index);
         check_field("max_value",  want.max_value,  got.max_value);
         check_field("min_index",  want.min_index,  got.min_index);
         check_field("min_value",  want.min_value,  got.min_value);
         check_field("rank_index", want.rank_index, got.rank_index);
         check_field("rank_value", want.rank_value, got.rank_value);
         check_field("rank_valid", want.rank_valid, got.rank_valid);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block hookup; every input starts at a known value
   // -------------------------------------------------------------------------
   logic             clock;
   logic             reset      = 1'b1;
   logic             start      = 1'b0;
   logic             busy;
   req_type          req_data   = '0;
   logic             rsp_strobe;
   rsp_type          rsp_data;
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_data   = '0;

   rank_tracker tracker = new();
   int          cycle_count = 0;
   bit          steady_phase;   // phase without sender gaps

   probability_vector_rank_engine #(.DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Take every strobed report; the receiver never holds results off.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) tracker.check_report(rsp_data);
   end

   // Guard against a hang: stop the run at a generous cycle budget.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL probability_vector_rank_engine");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drivers: inputs change on the falling edge, handshakes sampled on rising
   // -------------------------------------------------------------------------

   // Mostly back to back or short gaps, now and then a long pause.
   function int unsigned pick_gap();
      int unsigned r;
      if (steady_phase) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Hold start high until the transfer, note the command, then idle a bit.
   // A zero gap keeps start high into the next command without a drop.
   task automatic issue(logic [1:0] kind, logic [INDEX_W-1:0] pos,
                        logic [VALUE_W-1:0] val);
      req_type     cmd;
      int unsigned gap;
      cmd.kind     = kind;
      cmd.position = pos;
      cmd.value    = val;
      start    <= 1'b1;
      req_data <= cmd;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      tracker.note_command(cmd);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop start and wait until every report is in and the block is idle.
   task automatic settle();
      start <= 1'b0;
      forever begin
         @(posedge clock);
         if (!busy && tracker.pending_reports.size() == 0) break;
      end
      @(negedge clock);
   endtask

   // Write the active length only once the block is quiet.
   task automatic set_length(logic [LEN_W-1:0] len_val);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= len_val;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      tracker.length_reg = len_val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Favor zero, one and a few repeated values so that ties are common;
   // keep some raw values above one to hit saturation.
   function logic [VALUE_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 20) return '0;
      if (r < 35) return ONE_Q15;
      if (r < 55) begin
         case ($urandom_range(3))
            0:       return 16'd1;
            1:       return 16'd8192;
            2:       return 16'd16384;
            default: return 16'd32767;
         endcase
      end
      if (r < 90) return VALUE_W'($urandom_range(32768));
      return VALUE_W'($urandom_range(16'hFFFF));
   endfunction

   // Mostly in-range positions, sometimes anywhere in the field.
   function logic [INDEX_W-1:0] pick_position();
      if ($urandom_range(99) < 85) begin
         return INDEX_W'($urandom_range(tracker.live_length() - 1));
      end
      return INDEX_W'($urandom_range(DEPTH - 1));
   endfunction

   function logic [1:0] pick_kind();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 35) return KIND_WRITE;
      if (r < 60) return KIND_AVG;
      if (r < 95) return KIND_QUERY;
      return KIND_UNUSED;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      logic [LEN_W-1:0] phase_len;
      steady_phase = 1'b0;

      // Hold reset from time zero, release it on a falling edge.
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: full length after reset, all-zero vector first.
      set_length(6'd32);
      issue(KIND_QUERY,  5'd0,  16'd0);
      issue(KIND_QUERY,  5'd31, 16'd0);
      issue(KIND_WRITE,  5'd0,  ONE_Q15);
      issue(KIND_WRITE,  5'd31, 16'hFFFF);     // saturates to one
      issue(KIND_WRITE,  5'd5,  16'd1);
      issue(KIND_AVG,    5'd5,  ONE_Q15);      // (1 + 1.0) / 2, truncated
      issue(KIND_AVG,    5'd0,  16'hFFFF);     // average with saturated input
      issue(KIND_UNUSED, 5'd3,  16'd1234);     // no update, no rank
      issue(KIND_WRITE,  5'd7,  ONE_Q15);      // tie on the maximum
      issue(KIND_QUERY,  5'd31, 16'h5555);
      issue(KIND_QUERY,  5'd0,  16'd0);
      issue(KIND_QUERY,  5'd29, 16'd0);        // rank inside a run of equal values
      issue(KIND_AVG,    5'd12, 16'd7);

      // Single element: out-of-range position and rank.
      set_length(6'd1);
      issue(KIND_QUERY, 5'd0, 16'd0);
      issue(KIND_QUERY, 5'd1, 16'd0);
      issue(KIND_WRITE, 5'd3, 16'd99);         // ignored, beyond the length
      issue(KIND_AVG,   5'd0, 16'd3);

      // Zero length acts as one.
      set_length(6'd0);
      issue(KIND_WRITE, 5'd0, 16'd100);
      issue(KIND_QUERY, 5'd0, 16'd0);

      // Oversized length clamps to the full vector.
      set_length(6'd63);
      issue(KIND_QUERY, 5'd31, 16'd0);
      issue(KIND_QUERY, 5'd16, 16'd0);

      // Random phases over a spread of lengths, extremes included.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       phase_len = 6'd32;
            1:       phase_len = 6'd1;
            2:       phase_len = 6'd2;
            3:       phase_len = 6'd63;
            4:       phase_len = 6'd0;
            5:       phase_len = 6'd5;
            6:       phase_len = 6'd42;
            7:       phase_len = 6'd32;
            8:       phase_len = LEN_W'($urandom_range(32, 1));
            default: phase_len = LEN_W'($urandom_range(63));
         endcase
         set_length(phase_len);
         steady_phase = ($urandom_range(3) == 0);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            issue(pick_kind(), pick_position(), pick_value());
         end
      end

      // Drain: wait out the last report, then allow one full query latency.
      settle();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
         $display("PASS probability_vector_rank_engine");
      end else begin
         $display("FAIL probability_vector_rank_engine");
      end
      $finish;
   end

endmodule
